// ===== src/lzw_pkg.sv =====
// Shared types and constants for the LZW compressor.
// Used by the dictionary engine and the top level; no dependencies.
package lzw_pkg;

    // Default code width; the end marker is the all-ones code of this width
    localparam int CODE_BITS_DEF = 12;
    // First dictionary code after the literal bytes
    localparam int FIRST_ENTRY   = 256;
    // Depth of the queues as a power of two
    localparam int QUEUE_AW      = 1;

    // One input word as it waits in the front queue
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } item_t;

    // Engine status seen by the top level
    typedef struct packed {
        logic clearing;
        logic busy;
    } eng_status_t;

endpackage

// ===== src/lzw_fifo.sv =====
// Small register queue with show-ahead read data.
// Generic; no package dependencies.
module lzw_fifo #(
    parameter int W  = 8,
    parameter int AW = 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty,
    output logic         full
);
    localparam int DEPTH = 2 ** AW;

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          do_push, do_pop;

    // Qualify push and pop with the fill state
    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem_reg[rp_reg];

    // Advance pointers and count
    always_comb begin
        wp_next  = do_push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the word at the write pointer
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ===== src/lzw_engine.sv =====
// Back end of the LZW compressor: hashed dictionary lookup, insert and code emission.
// Depends on lzw_pkg.
module lzw_engine #(
    parameter int CODE_BITS = lzw_pkg::CODE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lzw_pkg::item_t         in_item,
    input  logic                   in_valid,
    output logic                   in_pop,
    output logic                   out_push,
    output logic [CODE_BITS-1:0]   out_code,
    output logic                   out_last,
    input  logic                   out_full,
    output lzw_pkg::eng_status_t   status
);
    import lzw_pkg::*;

    // Hash table with twice as many slots as codes, so probing always ends
    localparam int H      = CODE_BITS + 1;
    localparam int KEY_W  = CODE_BITS + 8;
    localparam int SLOT_W = 1 + KEY_W + CODE_BITS;
    localparam logic [CODE_BITS-1:0] END_CODE = '1;
    localparam logic [CODE_BITS-1:0] FIRST    = CODE_BITS'(FIRST_ENTRY);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_PROBE = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CODE_BITS-1:0] prefix_reg, prefix_next;
    logic                 pvalid_reg, pvalid_next;
    logic [CODE_BITS-1:0] nidx_reg, nidx_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic [H-1:0]         slot_reg, slot_next;
    logic [H-1:0]         clr_reg, clr_next;
    logic                 restart_reg, restart_next;
    logic [CODE_BITS-1:0] em_reg [3];
    logic [CODE_BITS-1:0] em_next [3];
    logic [1:0]           emn_reg, emn_next;
    logic [1:0]           emi_reg, emi_next;

    logic [SLOT_W-1:0]    mem [2**H];
    logic [SLOT_W-1:0]    rd_reg;
    logic                 we;
    logic [H-1:0]         wa;
    logic [SLOT_W-1:0]    wd;

    logic                 rd_valid;
    logic [KEY_W-1:0]     rd_key;
    logic [CODE_BITS-1:0] rd_code;
    logic [KEY_W-1:0]     key;

    function automatic logic [H-1:0] slot_hash(logic [CODE_BITS-1:0] p, logic [7:0] b);
        slot_hash = H'(p) ^ (H'(b) << (H - 8));
    endfunction

    assign rd_valid = rd_reg[SLOT_W-1];
    assign rd_key   = rd_reg[SLOT_W-2 -: KEY_W];
    assign rd_code  = rd_reg[CODE_BITS-1:0];
    assign key      = {prefix_reg, byte_reg};

    assign status.clearing = (state_reg == ST_CLEAR);
    assign status.busy     = (state_reg != ST_IDLE);
    assign out_code        = em_reg[emi_reg];
    assign out_last        = (emi_reg == emn_reg - 2'd1);

    // Sequence one word through lookup, update and emission
    always_comb begin
        state_next   = state_reg;
        prefix_next  = prefix_reg;
        pvalid_next  = pvalid_reg;
        nidx_next    = nidx_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        slot_next    = slot_reg;
        clr_next     = clr_reg;
        restart_next = restart_reg;
        em_next      = em_reg;
        emn_next     = emn_reg;
        emi_next     = emi_reg;
        in_pop       = 1'b0;
        out_push     = 1'b0;
        we           = 1'b0;
        wa           = slot_reg;
        wd           = {1'b1, key, nidx_reg};
        case (state_reg)
            ST_CLEAR: begin
                we       = 1'b1;
                wa       = clr_reg;
                wd       = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    in_pop    = 1'b1;
                    byte_next = in_item.data;
                    last_next = in_item.last;
                    if (!pvalid_reg) begin
                        if (in_item.last) begin
                            em_next[0]  = CODE_BITS'(in_item.data);
                            em_next[1]  = END_CODE;
                            emn_next    = 2'd2;
                            emi_next    = 2'd0;
                            prefix_next = '0;
                            state_next  = ST_EMIT;
                        end else begin
                            prefix_next = CODE_BITS'(in_item.data);
                            pvalid_next = 1'b1;
                        end
                    end else begin
                        slot_next  = slot_hash(prefix_reg, in_item.data);
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                emi_next = 2'd0;
                if (rd_valid && rd_key == key) begin
                    // Hit: extend the prefix, or emit it when the byte ends a file
                    if (last_reg) begin
                        em_next[0]  = rd_code;
                        em_next[1]  = END_CODE;
                        emn_next    = 2'd2;
                        prefix_next = '0;
                        pvalid_next = 1'b0;
                        state_next  = ST_EMIT;
                    end else begin
                        prefix_next = rd_code;
                        state_next  = ST_IDLE;
                    end
                end else if (rd_valid) begin
                    // Occupied by another key: try the next slot
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_PROBE;
                end else begin
                    // Miss: emit prefix, insert pair or restart numbering
                    em_next[0] = prefix_reg;
                    if (nidx_reg >= END_CODE) begin
                        restart_next = 1'b1;
                        nidx_next    = FIRST;
                    end else begin
                        we        = 1'b1;
                        nidx_next = nidx_reg + 1'b1;
                    end
                    if (last_reg) begin
                        em_next[1]  = CODE_BITS'(byte_reg);
                        em_next[2]  = END_CODE;
                        emn_next    = 2'd3;
                        prefix_next = '0;
                        pvalid_next = 1'b0;
                    end else begin
                        emn_next    = 2'd1;
                        prefix_next = CODE_BITS'(byte_reg);
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!out_full) begin
                    out_push = 1'b1;
                    if (out_last) begin
                        emi_next = 2'd0;
                        if (restart_reg) begin
                            restart_next = 1'b0;
                            clr_next     = '0;
                            state_next   = ST_CLEAR;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        emi_next = emi_reg + 2'd1;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            prefix_reg  <= '0;
            pvalid_reg  <= 1'b0;
            nidx_reg    <= FIRST;
            restart_reg <= 1'b0;
            emi_reg     <= 2'd0;
            emn_reg     <= 2'd1;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            prefix_reg  <= prefix_next;
            pvalid_reg  <= pvalid_next;
            nidx_reg    <= nidx_next;
            restart_reg <= restart_next;
            emi_reg     <= emi_next;
            emn_reg     <= emn_next;
        end
    end

    // Hold payload of the word in work
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        slot_reg <= slot_next;
        em_reg   <= em_next;
    end

    // Hash table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[slot_reg];
    end

endmodule

// ===== src/lzw_compressor.sv =====
// Top level of the LZW compressor: front queue, dictionary engine, result queue.
// Depends on lzw_pkg, lzw_fifo and lzw_engine.
//
// Usage: bytes enter on the s_ stream (s_tdata = byte, s_tlast = last byte of
// a file); codes leave on the m_ stream (m_tdata = code, m_tlast = final code
// caused by one byte). Codes 0-255 are literals, 256 up are dictionary
// entries, the all-ones code ends a file. The dictionary persists across files.
// A two-word queue in front takes bytes while the engine works; a two-word
// queue behind holds codes while the receiver stalls, and the engine waits.
// Steps: the engine takes each byte in its idle state, then runs a probe and a
// check state per hash probe (usually one probe; none for a byte that opens a
// file), then an emit state per code; the registered read port of the hash
// table is why a probe needs both states. After reset the engine clears its
// 2^(CODE_BITS+1)-slot hash table, one slot a cycle (8192 slots by default),
// and s_tready stays low meanwhile. The same sweep follows each dictionary
// restart when the code space is used up.
module lzw_compressor #(
    parameter int CODE_BITS = lzw_pkg::CODE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] data_byte
    input  logic                                s_tlast,   // last_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((CODE_BITS+7)/8)*8-1:0]      m_tdata,   // [CODE_BITS-1:0] code_word
    output logic                                m_tlast    // last_of_run
);
    import lzw_pkg::*;

    localparam int TDATA_W = ((CODE_BITS + 7) / 8) * 8;

    item_t                in_wdata, in_rdata;
    logic                 in_empty, in_full, in_pop;
    logic                 out_push, out_full, out_empty, eng_last;
    logic [CODE_BITS-1:0] eng_code;
    logic [CODE_BITS:0]   out_wdata, out_rdata;
    eng_status_t          status;

    // Accept words only when the front queue has room and the table is not being swept
    assign s_tready      = ~in_full & ~status.clearing;
    assign in_wdata.data = s_tdata;
    assign in_wdata.last = s_tlast;

    lzw_fifo #(.W($bits(item_t)), .AW(QUEUE_AW)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s_tvalid & s_tready),
        .wdata   (in_wdata),
        .pop     (in_pop),
        .rdata   (in_rdata),
        .empty   (in_empty),
        .full    (in_full)
    );

    lzw_engine #(.CODE_BITS(CODE_BITS)) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (in_rdata),
        .in_valid (~in_empty),
        .in_pop   (in_pop),
        .out_push (out_push),
        .out_code (eng_code),
        .out_last (eng_last),
        .out_full (out_full),
        .status   (status)
    );

    assign out_wdata = {eng_last, eng_code};

    lzw_fifo #(.W(CODE_BITS + 1), .AW(QUEUE_AW)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (out_push),
        .wdata   (out_wdata),
        .pop     (m_tvalid & m_tready),
        .rdata   (out_rdata),
        .empty   (out_empty),
        .full    (out_full)
    );

    // Drive the result stream from the queue head
    assign m_tvalid = ~out_empty;
    assign m_tdata  = TDATA_W'(out_rdata[CODE_BITS-1:0]);
    assign m_tlast  = out_rdata[CODE_BITS];

endmodule

// ===== src/lzw_checker.sv =====
// Port-level checks for the LZW compressor, bound to the top level.
// Depends on lzw_compressor's ports only.
module lzw_checker #(
    parameter int CODE_BITS = 12
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [((CODE_BITS+7)/8)*8-1:0] m_tdata,
    input logic                           m_tlast
);
    // Hold a stalled result word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // End marker always closes a run
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[CODE_BITS-1:0] == {CODE_BITS{1'b1}}) |-> m_tlast)
        else $error("end code without tlast");

    // No results right after reset
    a_rst_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Table sweep blocks input right after reset
    a_rst_in: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input ready during table sweep");

endmodule

bind lzw_compressor lzw_checker #(.CODE_BITS(CODE_BITS)) u_lzw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/tb.sv =====
// Self-checking testbench for lzw_compressor: directed table, a long output hold-off, then random files.
// Depends on lzw_pkg and the lzw_compressor RTL; runs on its own predictor.
`timescale 1ns / 1ps

module tb;

    localparam int CODE_W   = lzw_pkg::CODE_BITS_DEF;
    localparam int END_CODE = (1 << CODE_W) - 1;
    localparam int OUT_W    = ((CODE_W + 7) / 8) * 8;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;

    lzw_compressor #(.CODE_BITS(CODE_W)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #10 aclk = ~aclk;

    // Predictor state: current prefix and the dictionary as pair -> code
    int        prefix_code;
    bit        prefix_held;
    int        next_code;
    int        pair_to_code[int];
    int        restarts;
    int        new_codes[3];

    // Expected codes and their last flags, oldest first
    int        code_q[$];
    bit        run_end_q[$];

    int        errors;
    int        bytes_sent;
    int        codes_seen;
    int        idle_s;
    int        idle_m;
    bit        hold_now;

    // Stimulus table: code_cnt < 0 means the row is checked by the predictor
    typedef struct {
        logic [7:0] data;
        logic       last;
        int         code_cnt;
        int         c0;
        int         c1;
    } row_t;

    row_t stim_rows[$];

    // Append one row to the stimulus table
    task automatic add_row(logic [7:0] d, logic l, int cnt, int c0, int c1);
        row_t r;
        r.data     = d;
        r.last     = l;
        r.code_cnt = cnt;
        r.c0       = c0;
        r.c1       = c1;
        stim_rows.insert(stim_rows.size(), r);
    endtask

    // Compress one byte; returns how many codes it produces into new_codes
    function automatic int compress_byte(logic [7:0] b, logic l);
        int n;
        int pair;
        n = 0;
        if (!prefix_held) begin
            prefix_code = int'(b);
            prefix_held = 1'b1;
        end else begin
            pair = (prefix_code << 8) | int'(b);
            if (pair_to_code.exists(pair)) begin
                prefix_code = pair_to_code[pair];
            end else begin
                new_codes[n++] = prefix_code;
                if (next_code >= END_CODE) begin
                    // code space used up: empty the dictionary and restart
                    next_code = lzw_pkg::FIRST_ENTRY;
                    pair_to_code.delete();
                    restarts++;
                end else begin
                    pair_to_code[pair] = next_code;
                    next_code++;
                end
                prefix_code = int'(b);
            end
        end
        if (l) begin
            new_codes[n++] = prefix_code;
            new_codes[n++] = END_CODE;
            prefix_held = 1'b0;
            prefix_code = 0;
        end
        return n;
    endfunction

    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d (code %0d)", what, got, want, codes_seen);
        errors++;
    endtask

    // Offer one word and hold it until the block takes it
    task automatic send_word(row_t r);
        int n;
        while ($urandom_range(99) < idle_s) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r.data;
        s_tlast  <= r.last;
        do @(negedge aclk); while (!s_tready);
        n = compress_byte(r.data, r.last);
        if (r.code_cnt >= 0) begin
            n = r.code_cnt;
            new_codes[0] = r.c0;
            new_codes[1] = r.c1;
        end
        for (int k = 0; k < n; k++) begin
            code_q.insert(code_q.size(), new_codes[k]);
            run_end_q.insert(run_end_q.size(), k == n - 1);
        end
        bytes_sent++;
        @(posedge aclk);
    endtask

    // Let every expected code come out, then let the stream settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (code_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Send one random file; narrow alphabets give repeats and long matches
    task automatic send_file(int len, bit narrow);
        row_t r;
        for (int i = 0; i < len; i++) begin
            r.data     = narrow ? 8'(8'h41 + $urandom_range(2)) : 8'($urandom_range(255));
            r.last     = (i == len - 1);
            r.code_cnt = -1;
            send_word(r);
        end
    endtask

    // Receiver: random stalls, or one long hold-off when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_now) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_now = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= idle_m);
        end
    end

    // Check each word accepted at the coming edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (code_q.size() == 0) begin
                report("unexpected code", int'(m_tdata), -1);
            end else begin
                if (m_tdata != OUT_W'(code_q[0]))
                    report("code_word", int'(m_tdata), code_q[0]);
                if (m_tlast != run_end_q[0])
                    report("last_of_run", int'(m_tlast), int'(run_end_q[0]));
                void'(code_q.pop_front());
                void'(run_end_q.pop_front());
            end
            codes_seen++;
        end
    end

    initial begin
        #5ms;
        $display("timeout after %0d bytes, %0d codes", bytes_sent, codes_seen);
        $display("lzw_compressor regression: fail");
        $finish;
    end

    initial begin
        int len;
        prefix_code = 0;
        prefix_held = 1'b0;
        next_code   = lzw_pkg::FIRST_ENTRY;
        restarts    = 0;
        errors      = 0;
        bytes_sent  = 0;
        codes_seen  = 0;
        hold_now    = 1'b0;
        idle_s      = 0;
        idle_m      = 0;

        // Single-byte files at both extremes, then short files with repeats
        add_row(8'h00, 1'b1, 2, 0, END_CODE);
        add_row(8'hFF, 1'b1, 2, 255, END_CODE);
        add_row(8'h41, 1'b0, -1, 0, 0);
        add_row(8'h41, 1'b0, -1, 0, 0);
        add_row(8'h41, 1'b0, -1, 0, 0);
        add_row(8'h41, 1'b1, -1, 0, 0);
        add_row(8'h55, 1'b0, -1, 0, 0);
        add_row(8'hAA, 1'b0, -1, 0, 0);
        add_row(8'h55, 1'b0, -1, 0, 0);
        add_row(8'hAA, 1'b0, -1, 0, 0);
        add_row(8'h55, 1'b0, -1, 0, 0);
        add_row(8'hAA, 1'b1, -1, 0, 0);
        add_row(8'h41, 1'b0, -1, 0, 0);
        add_row(8'h41, 1'b1, -1, 0, 0);
        add_row(8'hFF, 1'b0, -1, 0, 0);
        add_row(8'h00, 1'b1, -1, 0, 0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i]) send_word(stim_rows[i]);
        drain();

        // Long receiver hold-off while bytes keep coming
        hold_now = 1'b1;
        send_file(30, 1'b1);
        drain();

        // Random files under the three stall mixes
        for (int ph = 0; ph < 3; ph++) begin
            idle_s = (ph == 0) ? 10 : (ph == 1) ? 79 : 0;
            idle_m = (ph == 0) ? 79 : (ph == 1) ? 10 : 0;
            for (int f = 0; f < 10; f++) begin
                len = int'($urandom_range(1, 15));
                send_file(len, 1'($urandom_range(1)));
            end
            drain();
        end

        $display("Sent %0d bytes, checked %0d codes, %0d dictionary restart(s),",
                 bytes_sent, codes_seen, restarts);
        $display("covering single-byte files, repeats, stall mixes and a long output hold-off.");
        if (errors == 0) begin
            $display("lzw_compressor regression: pass");
        end else begin
            $display("%0d mismatch(es)", errors);
            $display("lzw_compressor regression: fail");
        end
        $finish;
    end

endmodule
